/* src/bcc_pkg.sv */
`default_nettype none

package bcc_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 4096;

   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COLCNT_W   = 11;
   localparam int ROWCNT_W   = 13;
   localparam int TOTAL_W    = 22;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   localparam logic KIND_POS     = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = ROWCNT_W'(2);
   localparam logic [COLCNT_W-1:0] COL_COUNT_RST = COLCNT_W'(2);

   typedef struct packed {
      logic                 kind;
      logic [ROW_W-1:0]     square_row;
      logic [COL_W-1:0]     square_col;
      logic [TOTAL_W-1:0]   square_total;
      logic                 covered_ok;
      logic                 last;
   } bcc_rsp_type;

   // per-column line memory entry: pixel of the row above and the window
   // that was found when that pixel arrived
   typedef struct packed {
      logic pix;
      logic win;
   } bcc_line_type;

   typedef struct packed {
      logic        pos_vld;
      logic        vrd_vld;
      bcc_rsp_type pos;
      bcc_rsp_type vrd;
   } bcc_push_type;

endpackage

`default_nettype wire

/* src/bcc_if.sv */
`default_nettype none

interface bcc_req_if;
   logic valid;
   logic ready;
   logic pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface bcc_rsp_if import bcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [ROW_W-1:0]     square_row;
   logic [COL_W-1:0]     square_col;
   logic [TOTAL_W-1:0]   square_total;
   logic                 covered_ok;
   logic                 last;

   modport source (output valid, output kind, output square_row, output square_col,
                   output square_total, output covered_ok, output last, input ready);
   modport sink   (input valid, input kind, input square_row, input square_col,
                   input square_total, input covered_ok, input last, output ready);
endinterface

`default_nettype wire

/* src/binary_square_cover_check_unit.sv */
`default_nettype none

// Binary 2x2 opening check. Pixels of a row_count x col_count frame arrive in
// raster order on req, one beat per clock when rsp keeps up. For every full
// 2x2 window of ones a position beat (kind 0, one-based top-left row/column)
// goes out on rsp; the frame's last pixel adds a verdict beat (kind 1, last 1)
// with the square count and covered_ok, which is 0 when some one pixel lies in
// no full window. The previous row lives in a MAX_COLS x 2 bit line memory,
// read once and written once per pixel. Beats leave through a four-entry
// queue; req.ready is low while fewer than two entries are free. Rows not
// yet written are never consulted, so the memory needs no clearing after
// reset. A write to row_count (0x0) or col_count (0x4) restarts the frame;
// sizes of 0 act as 1 and sizes beyond the maximum clamp.
module binary_square_cover_check_unit import bcc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bcc_req_if.sink                    req,
   bcc_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [ROWCNT_W-1:0] row_count_ff;
   logic [COLCNT_W-1:0] col_count_ff;
   logic                csr_wr;
   logic                reg_sel;
   logic [ROW_W-1:0]    row_last;
   logic [COL_W-1:0]    col_last;
   logic                room;
   bcc_push_type        push;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RST;
         col_count_ff <= COL_COUNT_RST;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_ROW_COUNT: row_count_ff <= csr_pwdata[ROWCNT_W-1:0];
            REG_COL_COUNT: col_count_ff <= csr_pwdata[COLCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ROW_COUNT: csr_prdata = CSR_DATA_W'(row_count_ff);
         REG_COL_COUNT: csr_prdata = CSR_DATA_W'(col_count_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // index of the last row/column after clamping
   always_comb begin
      if (row_count_ff == '0) begin
         row_last = '0;
      end else if (row_count_ff > ROWCNT_W'(MAX_ROWS)) begin
         row_last = ROW_W'(MAX_ROWS - 1);
      end else begin
         row_last = ROW_W'(row_count_ff - ROWCNT_W'(1));
      end
      if (col_count_ff == '0) begin
         col_last = '0;
      end else if (col_count_ff > COLCNT_W'(MAX_COLS)) begin
         col_last = COL_W'(MAX_COLS - 1);
      end else begin
         col_last = COL_W'(col_count_ff - COLCNT_W'(1));
      end
   end

   bcc_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wr),
      .row_last (row_last),
      .col_last (col_last),
      .room     (room),
      .req      (req),
      .push     (push)
   );

   bcc_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

/* src/bcc_line_ram.sv */
`default_nettype none

module bcc_line_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/bcc_scan.sv */
`default_nettype none

module bcc_scan import bcc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             restart,
   input  wire logic [ROW_W-1:0] row_last,
   input  wire logic [COL_W-1:0] col_last,
   input  wire logic             room,
   bcc_req_if.sink               req,
   output bcc_push_type          push
);

   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               ul_pix_ff, ul_pix_in;
   logic               ul_win_ff, ul_win_in;
   logic               left_ff, left_in;
   logic               wl_ff, wl_in;
   logic [TOTAL_W-1:0] cnt_ff, cnt_in;
   logic               cov_ff, cov_in;
   logic               byp_ff;
   bcc_line_type       byp_data_ff;

   logic               accept;
   logic               col_end, row_end, has_up, has_left;
   logic [COL_W-1:0]   raddr;
   logic [1:0]         ram_rdata;
   bcc_line_type       up;
   bcc_line_type       wr;
   logic               wn, fail;
   logic [TOTAL_W-1:0] cnt_sum;

   assign req.ready = room;
   assign accept    = req.valid & room;

   assign col_end  = (col_ff == col_last);
   assign row_end  = (row_ff == row_last);
   assign has_up   = (row_ff != '0);
   assign has_left = (col_ff != '0);

   bcc_line_ram #(
      .WIDTH ($bits(bcc_line_type)),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock (clock),
      .we    (accept),
      .waddr (col_ff),
      .wdata (wr),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   // with a single column the next read hits the entry being written
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= accept && (raddr == col_ff);
      end
      byp_data_ff <= wr;
   end

   assign up = byp_ff ? byp_data_ff : bcc_line_type'(ram_rdata);

   assign wn = has_up & has_left & ul_pix_ff & up.pix & left_ff & req.pixel;

   always_comb begin
      fail = 1'b0;
      if (has_up && has_left && ul_pix_ff && !(ul_win_ff | up.win | wl_ff | wn)) begin
         fail = 1'b1;
      end
      if (has_up && col_end && up.pix && !(up.win | wn)) begin
         fail = 1'b1;
      end
      if (row_end && has_left && left_ff && !(wl_ff | wn)) begin
         fail = 1'b1;
      end
      if (row_end && col_end && req.pixel && !wn) begin
         fail = 1'b1;
      end
   end

   assign wr.pix  = req.pixel;
   assign wr.win  = wn;
   assign cnt_sum = cnt_ff + TOTAL_W'(wn);

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      ul_pix_in = ul_pix_ff;
      ul_win_in = ul_win_ff;
      left_in   = left_ff;
      wl_in     = wl_ff;
      cnt_in    = cnt_ff;
      cov_in    = cov_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
         cnt_in = '0;
         cov_in = 1'b1;
      end else if (accept) begin
         ul_pix_in = up.pix;
         ul_win_in = up.win;
         left_in   = req.pixel;
         wl_in     = wn;
         cnt_in    = cnt_sum;
         cov_in    = cov_ff & ~fail;
         col_in    = col_ff + COL_W'(1);
         if (col_end) begin
            col_in    = '0;
            ul_pix_in = 1'b0;
            ul_win_in = 1'b0;
            left_in   = 1'b0;
            wl_in     = 1'b0;
            row_in    = row_ff + ROW_W'(1);
            if (row_end) begin
               row_in = '0;
               cnt_in = '0;
               cov_in = 1'b1;
            end
         end
      end
   end

   assign raddr = (reset || restart) ? '0 : col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         ul_pix_ff <= 1'b0;
         ul_win_ff <= 1'b0;
         left_ff   <= 1'b0;
         wl_ff     <= 1'b0;
         cnt_ff    <= '0;
         cov_ff    <= 1'b1;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         ul_pix_ff <= ul_pix_in;
         ul_win_ff <= ul_win_in;
         left_ff   <= left_in;
         wl_ff     <= wl_in;
         cnt_ff    <= cnt_in;
         cov_ff    <= cov_in;
      end
   end

   always_comb begin
      push.pos_vld           = accept & wn;
      push.vrd_vld           = accept & col_end & row_end;
      push.pos.kind          = KIND_POS;
      push.pos.square_row    = row_ff;
      push.pos.square_col    = col_ff;
      push.pos.square_total  = '0;
      push.pos.covered_ok    = 1'b0;
      push.pos.last          = 1'b0;
      push.vrd.kind          = KIND_VERDICT;
      push.vrd.square_row    = '0;
      push.vrd.square_col    = '0;
      push.vrd.square_total  = cnt_sum;
      push.vrd.covered_ok    = cov_ff & ~fail;
      push.vrd.last          = 1'b1;
   end

endmodule

`default_nettype wire

/* src/bcc_rsp_fifo.sv */
`default_nettype none

module bcc_rsp_fifo import bcc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  bcc_push_type push,
   output logic        room,
   bcc_rsp_if.source   rsp
);

   bcc_rsp_type          q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wptr_ff, wptr_in;
   logic [RSP_PTR_W-1:0] rptr_ff, rptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 pop;
   logic [1:0]           n_push;
   bcc_rsp_type          first;
   bcc_rsp_type          head;

   assign n_push = {1'b0, push.pos_vld} + {1'b0, push.vrd_vld};
   assign first  = push.pos_vld ? push.pos : push.vrd;
   assign pop    = rsp.valid & rsp.ready;
   // an accepted pixel may add two beats
   assign room   = (cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   assign wptr_in = wptr_ff + RSP_PTR_W'(n_push);
   assign rptr_in = rptr_ff + RSP_PTR_W'(pop);
   assign cnt_in  = cnt_ff + RSP_CNT_W'(n_push) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_ff[wptr_ff] <= first;
      end
      if (n_push == 2'd2) begin
         q_ff[wptr_ff + RSP_PTR_W'(1)] <= push.vrd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign head             = q_ff[rptr_ff];
   assign rsp.valid        = (cnt_ff != '0);
   assign rsp.kind         = head.kind;
   assign rsp.square_row   = head.square_row;
   assign rsp.square_col   = head.square_col;
   assign rsp.square_total = head.square_total;
   assign rsp.covered_ok   = head.covered_ok;
   assign rsp.last         = head.last;

endmodule

`default_nettype wire

/* sim/tb_binary_square_cover_check_unit.sv */
`timescale 1ns / 1ps

module tb_binary_square_cover_check_unit;
   import bcc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PIXELS = 600;
   // most pixels sent of a frame that is left hanging
   localparam int CUT_MAX = 48;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ROW_COUNT = CSR_ADDR_W'({REG_ROW_COUNT, 2'b00});
   localparam logic [CSR_ADDR_W-1:0] ADDR_COL_COUNT = CSR_ADDR_W'({REG_COL_COUNT, 2'b00});

   typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_type;
   typedef enum {FR_SQUARES, FR_FLIPPED, FR_NOISE, FR_ONES, FR_ZEROS, FR_MIXED}
      frame_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bcc_req_if req_if ();
   bcc_rsp_if rsp_if ();

   binary_square_cover_check_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   gap_mode_type gap_mode = GAP_NONE;
   bit           pixels_to_send[$];
   bcc_rsp_type  due_beats[$];
   int           fail_count = 0;
   int           cycle_count = 0;

   // scan state of the frame in flight
   logic [ROWCNT_W-1:0] cfg_rows;
   logic [COLCNT_W-1:0] cfg_cols;
   bit [MAX_COLS-1:0]   prev_pix;
   bit [MAX_COLS-1:0]   cover_up;
   bit [MAX_COLS-1:0]   cover_lo;
   bit                  left_pix;
   bit                  upleft_pix;
   int unsigned         row_pos;
   int unsigned         col_pos;
   logic [22:0]         square_cnt;
   bit                  all_cov;

   function automatic void queue_beat(bcc_rsp_type b);
      due_beats.insert(due_beats.size(), b);
   endfunction

   function automatic void queue_pixel(bit p);
      pixels_to_send.insert(pixels_to_send.size(), p);
   endfunction

   function automatic int unsigned eff_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   function automatic void restart_frame();
      prev_pix = '0;
      cover_up = '0;
      cover_lo = '0;
      left_pix = 1'b0;
      upleft_pix = 1'b0;
      row_pos = 0;
      col_pos = 0;
      square_cnt = '0;
      all_cov = 1'b1;
   endfunction

   // advance the scan by one pixel and queue the beats it causes
   function automatic void scan_pixel(bit p);
      int unsigned nr, nc, r, c;
      bit          up;
      bcc_rsp_type beat;
      nr = eff_dim(cfg_rows, MAX_ROWS);
      nc = eff_dim(cfg_cols, MAX_COLS);
      r = row_pos;
      c = col_pos;
      if (c >= nc) c = nc - 1;
      up = prev_pix[c];
      if (r >= 1 && c >= 1 && upleft_pix && up && left_pix && p) begin
         square_cnt++;
         cover_up[c-1] = 1'b1;
         cover_up[c] = 1'b1;
         cover_lo[c-1] = 1'b1;
         cover_lo[c] = 1'b1;
         beat = '0;
         beat.kind = KIND_POS;
         beat.square_row = ROW_W'(r);
         beat.square_col = COL_W'(c);
         queue_beat(beat);
      end
      // a one pixel is judged once the last window that could hold it is known
      if (r >= 1) begin
         if (c >= 1 && upleft_pix && !cover_up[c-1]) all_cov = 1'b0;
         if (c == nc - 1 && up && !cover_up[c]) all_cov = 1'b0;
      end
      if (r == nr - 1) begin
         if (c >= 1 && left_pix && !cover_lo[c-1]) all_cov = 1'b0;
         if (c == nc - 1 && p && !cover_lo[c]) all_cov = 1'b0;
      end
      upleft_pix = up;
      prev_pix[c] = p;
      left_pix = p;
      c++;
      if (c >= nc) begin
         if (r >= nr - 1) begin
            beat = '0;
            beat.kind = KIND_VERDICT;
            beat.square_total = square_cnt[TOTAL_W-1:0];
            beat.covered_ok = all_cov;
            beat.last = 1'b1;
            queue_beat(beat);
            restart_frame();
            return;
         end
         cover_up = cover_lo;
         cover_lo = '0;
         left_pix = 1'b0;
         upleft_pix = 1'b0;
         c = 0;
         r++;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   function automatic void note_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("cycle %0d: %s", cycle_count, what);
   endfunction

   function automatic bit send_gap();
      case (gap_mode)
         GAP_SEND: return $urandom_range(99) < 69;
         GAP_BOTH: return $urandom_range(99) < 16;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit recv_stall();
      case (gap_mode)
         GAP_RECV: return $urandom_range(99) < 69;
         GAP_BOTH: return $urandom_range(99) < 16;
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.pixel <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) scan_pixel(req_if.pixel);
         if (!req_if.valid || req_if.ready) begin
            if (pixels_to_send.size() != 0 && !send_gap()) begin
               req_if.valid <= 1'b1;
               req_if.pixel <= pixels_to_send.pop_front();
            end else begin
               req_if.valid <= 1'b0;
               req_if.pixel <= 1'($urandom_range(1));
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      bcc_rsp_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind = rsp_if.kind;
            got.square_row = rsp_if.square_row;
            got.square_col = rsp_if.square_col;
            got.square_total = rsp_if.square_total;
            got.covered_ok = rsp_if.covered_ok;
            got.last = rsp_if.last;
            if (due_beats.size() == 0) begin
               note_failure($sformatf(
                  "unexpected beat kind %0d row %0d col %0d total %0d ok %0d",
                  got.kind, got.square_row, got.square_col, got.square_total,
                  got.covered_ok));
            end else begin
               want = due_beats.pop_front();
               if (got.kind !== want.kind || got.square_row !== want.square_row ||
                   got.square_col !== want.square_col ||
                   got.square_total !== want.square_total ||
                   got.covered_ok !== want.covered_ok || got.last !== want.last)
                  note_failure($sformatf({"beat mismatch: exp kind %0d row %0d col %0d",
                     " total %0d ok %0d last %0d, got kind %0d row %0d col %0d",
                     " total %0d ok %0d last %0d"},
                     want.kind, want.square_row, want.square_col, want.square_total,
                     want.covered_ok, want.last, got.kind, got.square_row, got.square_col,
                     got.square_total, got.covered_ok, got.last));
            end
         end
         rsp_if.ready <= !recv_stall();
      end
   end

   task automatic csr_access(input bit wr, input logic sel, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= (sel == REG_ROW_COUNT) ? ADDR_ROW_COUNT : ADDR_COL_COUNT;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_size_reg(input logic sel);
      logic [CSR_DATA_W-1:0] got, want;
      csr_access(1'b0, sel, '0, got);
      want = (sel == REG_ROW_COUNT) ? CSR_DATA_W'(cfg_rows) : CSR_DATA_W'(cfg_cols);
      if (got !== want)
         note_failure($sformatf("readback of %s: exp %0d got %0d",
            (sel == REG_ROW_COUNT) ? "row_count" : "col_count", want, got));
   endtask

   task automatic set_size_reg(input logic sel, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, sel, value, unused);
      if (sel == REG_ROW_COUNT) cfg_rows = value[ROWCNT_W-1:0];
      else cfg_cols = value[COLCNT_W-1:0];
      restart_frame();
      check_size_reg(sel);
   endtask

   task automatic wait_quiet();
      while (pixels_to_send.size() != 0 || req_if.valid || due_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic frame_style_type pick_style();
      int roll;
      roll = $urandom_range(9);
      if (roll < 6) return FR_SQUARES;
      if (roll < 8) return FR_FLIPPED;
      if (roll == 8) return FR_NOISE;
      return FR_ONES;
   endfunction

   // build one frame and queue its first keep pixels
   task automatic add_frame(input int nr, input int nc, input frame_style_type style,
                            input int keep);
      bit img[];
      int n, k, r0, c0, pct, idx;
      n = nr * nc;
      img = new[n];
      if ((style == FR_SQUARES || style == FR_FLIPPED) && (nr < 2 || nc < 2)) style = FR_NOISE;
      pct = $urandom_range(100);
      for (int i = 0; i < n; i++) begin
         case (style)
            FR_NOISE: img[i] = $urandom_range(99) < pct;
            FR_ONES: img[i] = 1'b1;
            default: img[i] = 1'b0;
         endcase
      end
      if (style == FR_SQUARES || style == FR_FLIPPED) begin
         k = $urandom_range(1, n / 4 + 1);
         repeat (k) begin
            r0 = $urandom_range(nr - 2);
            c0 = $urandom_range(nc - 2);
            img[r0*nc + c0] = 1'b1;
            img[r0*nc + c0 + 1] = 1'b1;
            img[(r0+1)*nc + c0] = 1'b1;
            img[(r0+1)*nc + c0 + 1] = 1'b1;
         end
         if (style == FR_FLIPPED) begin
            idx = $urandom_range(n - 1);
            img[idx] = !img[idx];
         end
      end
      for (int i = 0; i < keep && i < n; i++) queue_pixel(img[i]);
   endtask

   // program a size, then queue frames; returns the number of pixels queued
   task automatic run_phase(input int rows_raw, input int cols_raw, input gap_mode_type mode,
                            input int frames, input frame_style_type style, input bit cut_last,
                            output int queued);
      int nr, nc, n, keep;
      wait_quiet();
      gap_mode = mode;
      set_size_reg(REG_ROW_COUNT, CSR_DATA_W'(rows_raw));
      set_size_reg(REG_COL_COUNT, CSR_DATA_W'(cols_raw));
      nr = eff_dim(cfg_rows, MAX_ROWS);
      nc = eff_dim(cfg_cols, MAX_COLS);
      n = nr * nc;
      queued = 0;
      for (int f = 0; f < frames; f++) begin
         keep = n;
         // a cut frame is left hanging; the next size write must restart it
         if (cut_last && f == frames - 1 && n > 1)
            keep = $urandom_range(1, (n - 1 < CUT_MAX) ? n - 1 : CUT_MAX);
         add_frame(nr, nc, (style == FR_MIXED) ? pick_style() : style, keep);
         queued += keep;
      end
   endtask

   initial begin
      int queued, random_pixels, phase, rows_raw, cols_raw;
      bit [11:0] opening;
      cfg_rows = ROW_COUNT_RST;
      cfg_cols = COL_COUNT_RST;
      restart_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default 2x2 frame: full square, lone one, empty
      check_size_reg(REG_ROW_COUNT);
      check_size_reg(REG_COL_COUNT);
      opening = 12'b1111_1000_0000;
      for (int i = 11; i >= 0; i--) queue_pixel(opening[i]);

      // sizes at and beyond the limits, degenerate shapes
      run_phase(0, 5, GAP_NONE, 2, FR_NOISE, 1'b0, queued);
      run_phase(6, 0, GAP_SEND, 2, FR_NOISE, 1'b0, queued);
      run_phase(1, 1, GAP_RECV, 3, FR_NOISE, 1'b0, queued);
      run_phase(8191, 1, GAP_BOTH, 1, FR_NOISE, 1'b1, queued);
      run_phase(4096, 2, GAP_RECV, 1, FR_ONES, 1'b1, queued);
      run_phase(2, 2047, GAP_SEND, 1, FR_ONES, 1'b1, queued);
      run_phase(2, 1024, GAP_BOTH, 1, FR_SQUARES, 1'b1, queued);
      run_phase(3, 3, GAP_NONE, 1, FR_ONES, 1'b1, queued);

      random_pixels = 0;
      phase = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         rows_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
         cols_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         run_phase(rows_raw, cols_raw, gap_mode_type'(phase % 4), $urandom_range(1, 3),
                   FR_MIXED, $urandom_range(4) == 0, queued);
         random_pixels += queued;
         phase++;
      end

      wait_quiet();
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
